### sv/sorted_time_index_search_defines.svh
// ----------------------------------------------------------------------------
// Sorted time index search - assertion macros
// Shared concurrent assertion helpers, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIME_INDEX_SEARCH_DEFINES_SVH
`define SORTED_TIME_INDEX_SEARCH_DEFINES_SVH

// Same-cycle implication.
`define STIS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stis assertion failed");

// Next-cycle implication.
`define STIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stis assertion failed");

`endif

### sv/stis_pkg.sv
// ----------------------------------------------------------------------------
// Sorted time index search package
// Field widths and operation, mode and status codes.
// ----------------------------------------------------------------------------
package stis_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_BEFORE  = 2'd0,
    MODE_CLOSEST = 2'd1,
    MODE_AFTER   = 2'd2
  } mode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_REJECT  = 2'd2
  } status_e;

endpackage

### sv/stis_if.sv
// ----------------------------------------------------------------------------
// Sorted time index search channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface stis_req_if;
  import stis_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [TIME_W-1:0] time_value;
  logic [MODE_W-1:0] search_mode;

  modport source (output valid, operation, time_value, search_mode, input ready);
  modport sink   (input valid, operation, time_value, search_mode, output ready);
endinterface

interface stis_rsp_if;
  import stis_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] found_index;
  logic [ST_W-1:0]  status;

  modport source (output valid, found_index, status, input ready);
  modport sink   (input valid, found_index, status, output ready);
endinterface

### sv/sorted_time_index_search.sv
// ----------------------------------------------------------------------------
// Sorted time index search
// Nondecreasing timestamp table with lower-bound query over one memory port.
// ----------------------------------------------------------------------------
// Takes one transaction at a time. Clear and append pass from acceptance
// through the done state to the output register. A query runs a binary
// search with one table read per cycle through the single read port of
// the timestamp memory: it is accepted, probes the table, checks the
// lower-bound entry unless no entry is at or after the query time, fetches
// its predecessor in closest mode, and posts the result. A new request is
// taken once the previous result has been handed to the output register;
// that register frees the input side while the result waits downstream.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "sorted_time_index_search_defines.svh"

module sorted_time_index_search #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  stis_req_if.sink   in_i,
  stis_rsp_if.source out_o
);
  import stis_pkg::*;

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CHECK,
    S_PREV,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [TW-1:0]   last_q, last_d;
  logic [TW-1:0]   t_q, t_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [CW-1:0]   lo_q, lo_d;
  logic [CW-1:0]   hi_q, hi_d;
  logic [AW-1:0]   mid_q, mid_d;
  logic [CW-1:0]   lb_q, lb_d;
  logic [TW-1:0]   dn_q, dn_d;
  logic [AW-1:0]   res_idx_q, res_idx_d;
  status_e         res_st_q, res_st_d;
  logic            out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  status_e         out_st_q, out_st_d;

  logic [TW-1:0]   time_store_q [TABLE_DEPTH];
  logic [TW-1:0]   rd_data_q;
  logic            mem_we;
  logic [AW-1:0]   rd_addr;

  logic [TW-1:0]   in_time;
  logic            table_full;
  logic            append_bad;
  logic            less;
  logic [CW-1:0]   lo_n, hi_n;
  logic [SW-1:0]   mid_sum;
  logic [TW-1:0]   d_prev;

  assign in_time    = TW'(in_i.time_value);
  assign table_full = (count_q == CW'(TABLE_DEPTH));
  assign append_bad = table_full || ((count_q != '0) && (in_time < last_q));
  assign less       = (rd_data_q < t_q);
  assign lo_n       = less ? (CW'(mid_q) + CW'(1)) : lo_q;
  assign hi_n       = less ? hi_q : CW'(mid_q);
  assign mid_sum    = SW'(lo_n) + SW'(hi_n);
  assign d_prev     = t_q - rd_data_q;

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.found_index = out_idx_q;
  assign out_o.status      = out_st_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    last_d      = last_q;
    t_d         = t_q;
    mode_d      = mode_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    lb_d        = lb_q;
    dn_d        = dn_q;
    res_idx_d   = res_idx_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_st_d    = out_st_q;
    mem_we      = 1'b0;
    rd_addr     = mid_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          t_d       = in_time;
          mode_d    = in_i.search_mode;
          res_idx_d = '0;
          res_st_d  = ST_OK;
          state_d   = S_DONE;
          case (op_e'(in_i.operation))
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_APPEND: begin
              if (append_bad) begin
                res_st_d = ST_REJECT;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
                last_d  = in_time;
              end
            end
            OP_QUERY: begin
              if ((count_q == '0) || (in_i.search_mode > MODE_AFTER)) begin
                res_st_d = ST_NOMATCH;
              end else begin
                lo_d    = '0;
                hi_d    = count_q;
                mid_d   = AW'(count_q >> 1);
                rd_addr = mid_d;
                state_d = S_PROBE;
              end
            end
            default: ;
          endcase
        end
      end

      S_PROBE: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d   = AW'(mid_sum >> 1);
          rd_addr = mid_d;
        end else begin
          lb_d = lo_n;
          if (lo_n == count_q) begin
            // no entry at or after the query time
            state_d = S_DONE;
            if (mode_q == MODE_AFTER) begin
              res_st_d = ST_NOMATCH;
            end else begin
              res_idx_d = AW'(count_q - CW'(1));
            end
          end else begin
            rd_addr = lo_n[AW-1:0];
            state_d = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        state_d = S_DONE;
        if (rd_data_q == t_q) begin
          res_idx_d = lb_q[AW-1:0];
        end else begin
          case (mode_e'(mode_q))
            MODE_BEFORE: begin
              if (lb_q == '0) begin
                res_st_d = ST_NOMATCH;
              end else begin
                res_idx_d = AW'(lb_q - CW'(1));
              end
            end
            MODE_CLOSEST: begin
              if (lb_q != '0) begin
                dn_d    = rd_data_q - t_q;
                rd_addr = AW'(lb_q - CW'(1));
                state_d = S_PREV;
              end
            end
            default: begin
              res_idx_d = lb_q[AW-1:0];
            end
          endcase
        end
      end

      S_PREV: begin
        // tie goes to the earlier entry
        res_idx_d = (dn_q < d_prev) ? lb_q[AW-1:0] : AW'(lb_q - CW'(1));
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_idx_d   = IDX_W'(res_idx_q);
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      last_q      <= '0;
      t_q         <= '0;
      mode_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      lb_q        <= '0;
      dn_q        <= '0;
      res_idx_q   <= '0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_st_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      last_q      <= last_d;
      t_q         <= t_d;
      mode_q      <= mode_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      mid_q       <= mid_d;
      lb_q        <= lb_d;
      dn_q        <= dn_d;
      res_idx_q   <= res_idx_d;
      res_st_q    <= res_st_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_st_q    <= out_st_d;
    end
  end

  // timestamp table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_store_q[count_q[AW-1:0]] <= in_time;
    end
    rd_data_q <= time_store_q[rd_addr];
  end

  `STIS_ASSERT(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH))
  `STIS_ASSERT(a_probe_window, state_q == S_PROBE, (lo_q < hi_q) && (hi_q <= count_q))
  `STIS_ASSERT_NEXT(a_reject_keeps_table,
                    in_i.valid && in_i.ready && (in_i.operation == OP_APPEND) && append_bad,
                    $stable(count_q))

endmodule

### tb/sv/tb_sorted_time_index_search.sv
// ----------------------------------------------------------------------------
// Sorted time index search testbench
// Drives clear, append, query and unused-code transactions with random gaps
// and output stalls, predicts each result with a local copy of the timestamp
// table, and compares every result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_sorted_time_index_search;
  timeunit 1ns;
  timeprecision 1ps;

  import stis_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned RUN_LIMIT   = 600000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned MAX_REPORTS = 10;

  // codes outside the package enums
  localparam logic [OP_W-1:0]   OP_NONE   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] tval;
    logic [MODE_W-1:0] mode;
    bit                hold;   // wait for all results before presenting
  } stim_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [ST_W-1:0]  st;
  } answer_t;

  logic clk_i;
  logic rst_ni;

  stis_req_if req_ch ();
  stis_rsp_if rsp_ch ();

  sorted_time_index_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch.sink),
    .out_o  (rsp_ch.source)
  );

  always #5 clk_i = ~clk_i;

  stim_t   stim_q[$];
  answer_t answer_q[$];

  // timestamp table as the block should hold it
  logic [TIME_W-1:0] tbl [TABLE_DEPTH];
  int unsigned       tbl_count;

  // table contents as the stimulus generator expects them
  logic [TIME_W-1:0] gen_vals[$];

  int unsigned cycles;
  int unsigned errors;
  int unsigned results_seen;

  bit    req_taken;
  bit    rsp_taken;
  bit    tx_busy;
  stim_t tx_item;
  int    tx_wait;
  int    tx_quiet;
  int    rx_wait;
  int    rx_quiet;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic int unsigned lower_bound_of(input logic [TIME_W-1:0] t);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl[mid] < t) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  function automatic answer_t table_step(input stim_t it);
    answer_t           a;
    int unsigned       lb;
    logic [TIME_W-1:0] d_next;
    logic [TIME_W-1:0] d_prev;
    a.idx = '0;
    a.st  = ST_OK;
    case (it.op)
      OP_CLEAR: begin
        tbl_count = 0;
      end
      OP_APPEND: begin
        if (tbl_count >= TABLE_DEPTH ||
            (tbl_count > 0 && it.tval < tbl[tbl_count-1])) begin
          a.st = ST_REJECT;
        end else begin
          tbl[tbl_count] = it.tval;
          tbl_count++;
        end
      end
      OP_QUERY: begin
        if (tbl_count == 0 || it.mode == MODE_NONE) begin
          a.st = ST_NOMATCH;
        end else begin
          lb = lower_bound_of(it.tval);
          if (lb >= tbl_count) begin
            // every entry is below the query time
            if (it.mode == MODE_AFTER) begin
              a.st = ST_NOMATCH;
            end else begin
              a.idx = IDX_W'(tbl_count - 1);
            end
          end else if (tbl[lb] == it.tval) begin
            a.idx = IDX_W'(lb);
          end else if (it.mode == MODE_BEFORE) begin
            if (lb == 0) begin
              a.st = ST_NOMATCH;
            end else begin
              a.idx = IDX_W'(lb - 1);
            end
          end else if (it.mode == MODE_CLOSEST) begin
            if (lb != 0) begin
              d_next = tbl[lb] - it.tval;
              d_prev = it.tval - tbl[lb-1];
              // a tie keeps the earlier entry
              a.idx = (d_next < d_prev) ? IDX_W'(lb) : IDX_W'(lb - 1);
            end
          end else begin
            a.idx = IDX_W'(lb);
          end
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void add_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                                   input logic [MODE_W-1:0] mode, input bit hold);
    stim_t it;
    it.op   = op;
    it.tval = t;
    it.mode = mode;
    it.hold = hold;
    stim_q = {stim_q, it};
    if (op == OP_CLEAR) begin
      gen_vals.delete();
    end else if (op == OP_APPEND && gen_vals.size() < TABLE_DEPTH &&
                 (gen_vals.size() == 0 || t >= gen_vals[$])) begin
      gen_vals = {gen_vals, t};
    end
  endfunction

  function automatic void add_append(input logic [TIME_W-1:0] t);
    add_item(OP_APPEND, t, MODE_W'($urandom_range(0, 3)), $urandom_range(0, 49) == 0);
  endfunction

  function automatic void add_query(input logic [TIME_W-1:0] t, input logic [MODE_W-1:0] mode);
    add_item(OP_QUERY, t, mode, $urandom_range(0, 49) == 0);
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    if ($urandom_range(0, 19) == 0) begin
      return MODE_NONE;
    end
    return MODE_W'($urandom_range(MODE_BEFORE, MODE_AFTER));
  endfunction

  function automatic logic [TIME_W-1:0] pick_query_time();
    int unsigned       n;
    int unsigned       k;
    logic [TIME_W:0]   mid_sum;
    n = gen_vals.size();
    if (n == 0) begin
      return $urandom;
    end
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 6))
      0, 1: return gen_vals[k];
      2: return gen_vals[k] + 1'b1;
      3: return gen_vals[k] - 1'b1;
      4: begin
        if (k + 1 < n) begin
          mid_sum = {1'b0, gen_vals[k]} + {1'b0, gen_vals[k+1]};
          return mid_sum[TIME_W:1] + TIME_W'($urandom_range(0, 1));
        end
        return gen_vals[k] + TIME_W'($urandom_range(0, 1000));
      end
      5: return ($urandom_range(0, 1) == 0) ? '0 : TIME_MAX;
      default: return $urandom;
    endcase
  endfunction

  // next nondecreasing timestamp, saturating at the top of the range
  function automatic logic [TIME_W-1:0] next_time(input int unsigned step_max);
    longint unsigned sum;
    if (gen_vals.size() == 0) begin
      return ($urandom_range(0, 3) == 0) ? '0 : TIME_W'($urandom_range(0, 32'h7fff_ffff));
    end
    sum = longint'(gen_vals[$]) + $urandom_range(0, step_max);
    return (sum > longint'(TIME_MAX)) ? TIME_MAX : TIME_W'(sum);
  endfunction

  function automatic void add_episode();
    int unsigned n_app;
    int unsigned n_qry;
    int unsigned step_max;
    case ($urandom_range(0, 3))
      0: step_max = 0;
      1: step_max = 3;
      2: step_max = 1000;
      default: step_max = 1 << 20;
    endcase
    if ($urandom_range(0, 7) != 0) begin
      add_item(OP_CLEAR, $urandom, MODE_W'($urandom_range(0, 3)), 1'b0);
    end
    n_app = $urandom_range(1, 40);
    n_qry = $urandom_range(5, 25);
    while (n_app + n_qry > 0) begin
      if (n_app > 0 && ($urandom_range(0, 1) == 0 || n_qry == 0)) begin
        n_app--;
        if (gen_vals.size() != 0 && gen_vals[$] != 0 && $urandom_range(0, 11) == 0) begin
          // out of order and so refused, unless the subtraction wraps below zero
          add_append(gen_vals[$] - 1'b1 - TIME_W'($urandom_range(0, 100)));
        end else begin
          add_append(next_time(step_max));
        end
      end else begin
        n_qry--;
        if ($urandom_range(0, 29) == 0) begin
          add_item(OP_NONE, $urandom, MODE_W'($urandom_range(0, 3)), 1'b0);
        end else begin
          add_query(pick_query_time(), pick_mode());
        end
      end
    end
  endfunction

  function automatic void add_noise();
    int unsigned n;
    n = $urandom_range(5, 15);
    repeat (n) begin
      add_item(OP_W'($urandom_range(0, 3)), $urandom, MODE_W'($urandom_range(0, 3)), 1'b0);
    end
  endfunction

  function automatic void add_full_table();
    add_item(OP_CLEAR, $urandom, MODE_W'($urandom_range(0, 3)), 1'b1);
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      add_append(next_time(3000000));
      if (i % 128 == 127) begin
        add_query(pick_query_time(), pick_mode());
      end
    end
    // full: refused even when in order
    add_append(gen_vals[$]);
    add_append(TIME_MAX);
    add_query(gen_vals[TABLE_DEPTH-1], MODE_BEFORE);
    add_query(TIME_MAX, MODE_CLOSEST);
    add_query(gen_vals[0], MODE_AFTER);
    add_item(OP_QUERY, '0, MODE_BEFORE, 1'b1);
    repeat (20) begin
      add_query(pick_query_time(), pick_mode());
    end
  endfunction

  function automatic void add_directed();
    add_item(OP_QUERY, 32'd100, MODE_BEFORE, 1'b0);      // empty table
    add_item(OP_QUERY, TIME_MAX, MODE_NONE, 1'b0);
    add_item(OP_NONE, TIME_MAX, MODE_NONE, 1'b0);
    add_item(OP_APPEND, 32'd100, MODE_BEFORE, 1'b0);
    add_item(OP_APPEND, 32'd100, MODE_CLOSEST, 1'b0);   // duplicate is in order
    add_item(OP_APPEND, 32'd200, MODE_AFTER, 1'b0);
    add_item(OP_APPEND, 32'd50, MODE_NONE, 1'b0);       // out of order
    add_item(OP_APPEND, 32'd300, MODE_BEFORE, 1'b1);
    add_item(OP_QUERY, 32'd100, MODE_AFTER, 1'b0);
    add_item(OP_QUERY, 32'd50, MODE_BEFORE, 1'b0);      // below first entry
    add_item(OP_QUERY, 32'd50, MODE_CLOSEST, 1'b0);
    add_item(OP_QUERY, 32'd50, MODE_AFTER, 1'b0);
    add_item(OP_QUERY, 32'd400, MODE_AFTER, 1'b0);      // past the end
    add_item(OP_QUERY, 32'd400, MODE_BEFORE, 1'b0);
    add_item(OP_QUERY, 32'd400, MODE_CLOSEST, 1'b0);
    add_item(OP_QUERY, 32'd150, MODE_CLOSEST, 1'b0);    // equal distance
    add_item(OP_QUERY, 32'd160, MODE_CLOSEST, 1'b0);
    add_item(OP_QUERY, 32'd150, MODE_BEFORE, 1'b0);
    add_item(OP_QUERY, 32'd150, MODE_AFTER, 1'b0);
    add_item(OP_QUERY, 32'd150, MODE_NONE, 1'b0);
    add_item(OP_APPEND, TIME_MAX, MODE_BEFORE, 1'b0);
    add_item(OP_QUERY, TIME_MAX, MODE_BEFORE, 1'b0);
    add_item(OP_APPEND, '0, MODE_AFTER, 1'b0);
    add_item(OP_CLEAR, TIME_MAX, MODE_NONE, 1'b0);
    add_item(OP_APPEND, '0, MODE_BEFORE, 1'b0);
    add_item(OP_QUERY, '0, MODE_CLOSEST, 1'b0);
  endfunction

  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(8, 40);
    end
    return $urandom_range(0, 19);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      answer_q = {answer_q, table_step(tx_item)};
      req_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_taken) begin
        tx_busy   = 1'b0;
        req_taken = 1'b0;
      end
      if (!tx_busy && stim_q.size() != 0) begin
        if (tx_wait < 0) begin
          tx_wait = draw_wait(tx_quiet);
        end
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (!stim_q[0].hold || answer_q.size() == 0) begin
          tx_item = stim_q.pop_front();
          tx_busy = 1'b1;
          tx_wait = -1;
        end
      end
      req_ch.valid       <= tx_busy;
      req_ch.operation   <= tx_busy ? tx_item.op   : OP_W'($urandom);
      req_ch.time_value  <= tx_busy ? tx_item.tval : TIME_W'($urandom);
      req_ch.search_mode <= tx_busy ? tx_item.mode : MODE_W'($urandom);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      cycles++;
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_taken = 1'b1;
        results_seen++;
        if (answer_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("result %0d with no transaction outstanding: index %0d status %0d",
                     results_seen, rsp_ch.found_index, rsp_ch.status);
          end
        end else begin
          want = answer_q.pop_front();
          if (rsp_ch.found_index !== want.idx || rsp_ch.status !== want.st) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("result %0d mismatch: index exp %0d got %0d, status exp %0d got %0d",
                       results_seen, want.idx, rsp_ch.found_index, want.st, rsp_ch.status);
            end
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_taken) begin
        rx_wait   = draw_wait(rx_quiet);
        rsp_taken = 1'b0;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OP_CLEAR;
    req_ch.time_value  = '0;
    req_ch.search_mode = MODE_BEFORE;
    rsp_ch.ready       = 1'b0;
    tbl_count          = 0;
    cycles             = 0;
    errors             = 0;
    results_seen       = 0;
    req_taken          = 1'b0;
    rsp_taken          = 1'b0;
    tx_busy            = 1'b0;
    tx_wait            = -1;
    tx_quiet           = 0;
    rx_wait            = 0;
    rx_quiet           = 0;

    add_directed();
    while (stim_q.size() < 40) begin
      if ($urandom_range(0, 4) == 0) begin
        add_noise();
      end else begin
        add_episode();
      end
    end
    add_full_table();

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (stim_q.size() == 0 && !tx_busy && answer_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_sorted_time_index_search OK");
    end else begin
      $display("tb_sorted_time_index_search NOT OK");
    end
    $finish;
  end

  initial begin
    wait (cycles >= RUN_LIMIT);
    $display("timeout after %0d cycles, %0d transactions outstanding",
             cycles, answer_q.size());
    $display("tb_sorted_time_index_search NOT OK");
    $finish;
  end

endmodule
